### src/rime_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rime_pkg;

	// configuration register width and indexes
	localparam int unsigned CFG_W = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

	// transform modes
	localparam int unsigned MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_COPY     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT90    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT180   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT270   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROW_FLIP = 3'd4;
	localparam logic [MODE_W-1:0] MODE_COL_FLIP = 3'd5;

	// command actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EMIT = 1'b1;

	localparam int unsigned PIXEL_W = 16;

	typedef struct packed {
		logic               action;
		logic [PIXEL_W-1:0] pixel_in;
	} cmd_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_out;
		logic               last_pixel;
	} result_t;

endpackage
`default_nettype wire

### src/rime_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rime_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule
`default_nettype wire

### src/rime_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rime_front #(
	parameter int unsigned MAX_WIDTH = 64,
	parameter int unsigned MAX_HEIGHT = 64,
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned QW = AW + rime_pkg::PIXEL_W + 2
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire rime_pkg::cmd_t                   cmd,
	input  wire logic                             full,
	output logic                                  busy,
	input  wire logic                             cfg_valid,
	input  wire logic [rime_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rime_pkg::CFG_W-1:0]       cfg_data,
	output logic                                  cfg_ready,
	output logic                                  push,
	output logic [QW-1:0]                         push_data
);

	localparam int unsigned MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int unsigned SW = $clog2(MAXD + 1);
	localparam int unsigned EW = (SW > rime_pkg::CFG_W) ? SW : rime_pkg::CFG_W;
	localparam int unsigned PW = 2 * SW;
	localparam int unsigned LPW = $clog2(DEPTH + 1);

	logic [rime_pkg::CFG_W-1:0]  width_q, height_q;
	logic [rime_pkg::MODE_W-1:0] mode_q;
	logic [LPW-1:0]              load_pos_q;
	logic [SW-1:0]               outer_q, inner_q;

	logic                        accept;
	logic [EW-1:0]               w_ext, h_ext;
	logic [SW-1:0]               w, h;
	logic [rime_pkg::MODE_W-1:0] mode;
	logic                        outer_cols;
	logic [SW-1:0]               outer_n, inner_n;
	logic [SW-1:0]               o_c, n_c, row, col, n_inc, o_inc;
	logic [SW-1:0]               outer_d, inner_d;
	logic                        last;
	logic [PW-1:0]               total, idx;
	logic [LPW-1:0]              lp_c;
	logic [AW-1:0]               addr;

	assign busy = full;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			mode_q   <= rime_pkg::MODE_COPY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rime_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data;
				rime_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				rime_pkg::REG_TRANSFORM_MODE: mode_q   <= cfg_data[rime_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes, clamped to 1..max
	always_comb begin
		w_ext = EW'(width_q);
		h_ext = EW'(height_q);
		if (width_q == '0) begin
			w = SW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w = SW'(MAX_WIDTH);
		end else begin
			w = w_ext[SW-1:0];
		end
		if (height_q == '0) begin
			h = SW'(1);
		end else if (h_ext > EW'(MAX_HEIGHT)) begin
			h = SW'(MAX_HEIGHT);
		end else begin
			h = h_ext[SW-1:0];
		end
		mode = (mode_q > rime_pkg::MODE_COL_FLIP) ? rime_pkg::MODE_COPY : mode_q;
		outer_cols = (mode == rime_pkg::MODE_ROT90) || (mode == rime_pkg::MODE_ROT270);
		outer_n = outer_cols ? w : h;
		inner_n = outer_cols ? h : w;
		total = PW'(w) * PW'(h);
	end

	// emit traversal: store row and column for the current position
	always_comb begin
		if ((outer_q >= outer_n) || (inner_q >= inner_n)) begin
			o_c = '0;
			n_c = '0;
		end else begin
			o_c = outer_q;
			n_c = inner_q;
		end
		case (mode)
			rime_pkg::MODE_ROT90: begin
				row = h - SW'(1) - n_c;
				col = o_c;
			end
			rime_pkg::MODE_ROT180: begin
				row = h - SW'(1) - o_c;
				col = w - SW'(1) - n_c;
			end
			rime_pkg::MODE_ROT270: begin
				row = n_c;
				col = w - SW'(1) - o_c;
			end
			rime_pkg::MODE_ROW_FLIP: begin
				row = h - SW'(1) - o_c;
				col = n_c;
			end
			rime_pkg::MODE_COL_FLIP: begin
				row = o_c;
				col = w - SW'(1) - n_c;
			end
			default: begin
				row = o_c;
				col = n_c;
			end
		endcase
		idx = PW'(row) * PW'(w) + PW'(col);

		// advance the counters
		n_inc = n_c + SW'(1);
		o_inc = o_c + SW'(1);
		last = 1'b0;
		if (n_inc >= inner_n) begin
			inner_d = '0;
			if (o_inc >= outer_n) begin
				outer_d = '0;
				last = 1'b1;
			end else begin
				outer_d = o_inc;
			end
		end else begin
			inner_d = n_inc;
			outer_d = o_c;
		end
	end

	// load position wraps at the image size
	always_comb begin
		lp_c = (PW'(load_pos_q) >= total) ? '0 : load_pos_q;
		if (cmd.action == rime_pkg::ACT_EMIT) begin
			addr = idx[AW-1:0];
		end else begin
			addr = lp_c[AW-1:0];
		end
	end

	assign push = accept;
	assign push_data = {cmd.action == rime_pkg::ACT_LOAD, last, cmd.pixel_in, addr};

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			outer_q    <= '0;
			inner_q    <= '0;
		end else if (accept) begin
			if (cmd.action == rime_pkg::ACT_EMIT) begin
				outer_q <= outer_d;
				inner_q <= inner_d;
			end else begin
				load_pos_q <= lp_c + LPW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### src/rime_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rime_queue #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output logic      [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_data = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### src/rime_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rime_back #(
	parameter int unsigned MAX_WIDTH = 64,
	parameter int unsigned MAX_HEIGHT = 64,
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned QW = AW + rime_pkg::PIXEL_W + 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              not_empty,
	input  wire logic [QW-1:0]     head_data,
	output logic                   pop,
	output logic                   result_valid,
	output rime_pkg::result_t      result
);

	logic                        is_write, is_last;
	logic [rime_pkg::PIXEL_W-1:0] wdata, rdata;
	logic [AW-1:0]               addr;
	logic                        rd_s1, last_s1;

	// unpack the queued operation; the back end drains one every cycle while the queue is not empty
	assign is_write = head_data[QW-1];
	assign is_last  = head_data[QW-2];
	assign wdata    = head_data[AW +: rime_pkg::PIXEL_W];
	assign addr     = head_data[AW-1:0];
	assign pop      = not_empty;

	rime_ram #(
		.WIDTH(rime_pkg::PIXEL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.en   (pop),
		.we   (is_write),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	// read strobe travels alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= pop && !is_write;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= is_last;
	end

	assign result_valid      = rd_s1;
	assign result.pixel_out  = rdata;
	assign result.last_pixel = last_s1;

endmodule
`default_nettype wire

### src/image_rotate_mirror_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Image rotate / mirror engine. Pixels are loaded in row-major order (action load) and
// read back one per emit command in copy, rotate 90/180/270, row-flip or column-flip
// order. One command is taken every clock cycle while busy is low; a command is a
// single access to the pixel store, a single-port RAM, and the front end computes
// the store address (one row*width+column multiply-add) in the cycle the command is
// taken. The command is registered in the operation queue, and the store read and the
// result_valid strobe are registered when the back end pops it; the result is held for
// exactly one cycle. Results come in command order and cannot be held off. The store
// powers up unwritten and needs no clearing. Configuration writes (cfg_ready is always
// high) must only happen while no emit is in flight.
module image_rotate_mirror_engine_core #(
	parameter int unsigned MAX_WIDTH = 64,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire rime_pkg::cmd_t                 cmd,
	output logic                                busy,
	input  wire logic                           cfg_valid,
	input  wire logic [rime_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rime_pkg::CFG_W-1:0]     cfg_data,
	output logic                                cfg_ready,
	output logic                                result_valid,
	output rime_pkg::result_t                   result
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned QW = AW + rime_pkg::PIXEL_W + 2;

	logic          push, pop, full, not_empty;
	logic [QW-1:0] push_data, head_data;

	// front end: configuration, counters and address generation
	rime_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.full     (full),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg_ready(cfg_ready),
		.push     (push),
		.push_data(push_data)
	);

	// operation queue between front and back
	rime_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.head_data(head_data)
	);

	// back end: pixel store access and result strobe
	rime_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head_data   (head_data),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
`default_nettype wire

### test/tb_image_rotate_mirror_engine_core.sv
`timescale 1ns / 1ps
module tb_image_rotate_mirror_engine_core;
	import rime_pkg::*;

	localparam int unsigned MAX_W = 64;
	localparam int unsigned MAX_H = 64;
	localparam int unsigned ITEM_TARGET = 1800;
	localparam int unsigned TAIL_ITEMS = 200;
	localparam int unsigned STALL_LIMIT = 500;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	cmd_t                 cmd = '0;
	logic                 busy;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 cfg_ready;
	logic                 result_valid;
	result_t              result;

	image_rotate_mirror_engine_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_ready(cfg_ready),
		.result_valid(result_valid),
		.result(result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// commands waiting to go out, pixel results waiting to come back
	cmd_t    pending_cmds[$];
	result_t want_results[$];

	// predicted engine state
	logic [PIXEL_W-1:0] img_store [MAX_W*MAX_H];
	int unsigned        wr_pos = 0;
	int unsigned        out_major = 0;
	int unsigned        out_minor = 0;
	logic [CFG_W-1:0]   size_w = 7'd64;
	logic [CFG_W-1:0]   size_h = 7'd64;
	logic [MODE_W-1:0]  xform = MODE_COPY;

	// stimulus-side view of what has been loaded so far
	logic [CFG_W-1:0] plan_w = 7'd64;
	logic [CFG_W-1:0] plan_h = 7'd64;
	int unsigned      plan_pos = 0;
	int unsigned      loaded_span = 0;

	bit          cmd_taken = 1'b0;
	bit          sender_hold = 1'b0;
	bit          quiet_tail = 1'b0;
	int unsigned idle_odds = 0;
	int unsigned gap_left = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned n_items = 0;
	int unsigned n_results = 0;
	int unsigned n_last = 0;
	int unsigned n_settings = 0;

	// zero acts as one, oversize saturates
	function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	// work out what one accepted command does to the engine
	function automatic void predict_command(cmd_t c);
		int unsigned w, h, total, outer_n, inner_n, row, col;
		logic [MODE_W-1:0] m;
		bit outer_cols;
		result_t r;
		w = eff_dim(size_w, MAX_W);
		h = eff_dim(size_h, MAX_H);
		total = w * h;
		m = (xform > MODE_COL_FLIP) ? MODE_COPY : xform;
		if (c.action == ACT_LOAD) begin
			if (wr_pos >= total)
				wr_pos = 0;
			img_store[wr_pos] = c.pixel_in;
			wr_pos++;
			return;
		end
		outer_cols = (m == MODE_ROT90 || m == MODE_ROT270);
		outer_n = outer_cols ? w : h;
		inner_n = outer_cols ? h : w;
		if (out_major >= outer_n || out_minor >= inner_n) begin
			out_major = 0;
			out_minor = 0;
		end
		case (m)
			MODE_ROT90: begin
				row = h - 1 - out_minor;
				col = out_major;
			end
			MODE_ROT180: begin
				row = h - 1 - out_major;
				col = w - 1 - out_minor;
			end
			MODE_ROT270: begin
				row = out_minor;
				col = w - 1 - out_major;
			end
			MODE_ROW_FLIP: begin
				row = h - 1 - out_major;
				col = out_minor;
			end
			MODE_COL_FLIP: begin
				row = out_major;
				col = w - 1 - out_minor;
			end
			default: begin
				row = out_major;
				col = out_minor;
			end
		endcase
		r.pixel_out = img_store[row * w + col];
		r.last_pixel = 1'b0;
		out_minor++;
		if (out_minor >= inner_n) begin
			out_minor = 0;
			out_major++;
			if (out_major >= outer_n) begin
				out_major = 0;
				r.last_pixel = 1'b1;
			end
		end
		want_results.push_back(r);
	endfunction

	// monitor: results, command and register transfers, watchdog
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				n_results++;
				if (result.last_pixel)
					n_last++;
				if (want_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel result: pixel %h last %b",
							result.pixel_out, result.last_pixel);
				end else begin
					want = want_results.pop_front();
					if (result.pixel_out !== want.pixel_out ||
							result.last_pixel !== want.last_pixel) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel result %0d: expected pixel %h last %b, %s",
								n_results, want.pixel_out, want.last_pixel,
								$sformatf("got pixel %h last %b",
								result.pixel_out, result.last_pixel));
					end
				end
			end
			if (start && !busy) begin
				predict_command(cmd);
				cmd_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:    size_w = cfg_data;
					REG_IMAGE_HEIGHT:   size_h = cfg_data;
					REG_TRANSFORM_MODE: xform = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("tb_image_rotate_mirror_engine_core failed");
				$finish;
			end
		end
	end

	// driver: one command per transfer, random idle bursts
	always @(negedge clk) begin : driver
		logic nxt_start;
		cmd_t nxt_cmd;
		nxt_start = start;
		nxt_cmd = cmd;
		if (cmd_taken) begin
			void'(pending_cmds.pop_front());
			cmd_taken = 1'b0;
			nxt_start = 1'b0;
		end
		if (!arst_n) begin
			nxt_start = 1'b0;
		end else if (!nxt_start) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cmds.size() != 0 && !sender_hold) begin
				if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					gap_left = $urandom_range(0, 3);
				end else begin
					nxt_start = 1'b1;
					nxt_cmd = pending_cmds[0];
				end
			end
		end
		start <= nxt_start;
		cmd <= nxt_cmd;
	end

	// queue a load, tracking the loaded prefix of the store
	function automatic void queue_load(logic [PIXEL_W-1:0] px);
		int unsigned total;
		cmd_t c;
		total = eff_dim(plan_w, MAX_W) * eff_dim(plan_h, MAX_H);
		if (plan_pos >= total)
			plan_pos = 0;
		plan_pos++;
		if (plan_pos > loaded_span)
			loaded_span = plan_pos;
		c.action = ACT_LOAD;
		c.pixel_in = px;
		pending_cmds.push_back(c);
		n_items++;
	endfunction

	// queue an emit, only once every pixel of the image has been written
	function automatic void queue_emit();
		int unsigned total;
		cmd_t c;
		total = eff_dim(plan_w, MAX_W) * eff_dim(plan_h, MAX_H);
		if (total > loaded_span)
			return;
		c.action = ACT_EMIT;
		c.pixel_in = PIXEL_W'($urandom_range(0, 16'hFFFF));
		pending_cmds.push_back(c);
		n_items++;
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIXEL_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// one register transfer; valid stays up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH)
			plan_w = val;
		else if (idx == REG_IMAGE_HEIGHT)
			plan_h = val;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// hold until every command is out and every pixel result is back
	task automatic drain();
		sender_hold = 1'b0;
		while (pending_cmds.size() != 0 || start || want_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] w_val, h_val;
		logic [MODE_W-1:0] m_val;
		int unsigned total, n_emit, pause_at, k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero sizes act as a single pixel, extreme pixel values
		write_reg(REG_IMAGE_WIDTH, 7'd0);
		write_reg(REG_IMAGE_HEIGHT, 7'd0);
		write_reg(REG_TRANSFORM_MODE, CFG_W'(MODE_COPY));
		end_writes();
		queue_load(16'hFFFF);
		queue_emit();
		queue_emit();
		queue_load(16'h0000);
		queue_emit();
		drain();

		// 2x2 rotate 90 with emit wrap, load wrap after the size change
		write_reg(REG_IMAGE_WIDTH, 7'd2);
		write_reg(REG_IMAGE_HEIGHT, 7'd2);
		write_reg(REG_TRANSFORM_MODE, CFG_W'(MODE_ROT90));
		end_writes();
		queue_load(16'h8000);
		queue_load(16'h0001);
		queue_load(16'h7FFF);
		queue_load(16'hAAAA);
		for (k = 0; k < 5; k++)
			queue_emit();
		drain();

		// unused mode code behaves as copy, emit position carries over the mode change
		write_reg(REG_TRANSFORM_MODE, 7'd7);
		end_writes();
		for (k = 0; k < 4; k++)
			queue_emit();
		drain();

		// random phases: new mode (often new sizes), full or partial image load, emits with stray loads
		while (n_items < ITEM_TARGET) begin
			if (n_items + TAIL_ITEMS >= ITEM_TARGET)
				quiet_tail = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: begin
						w_val = CFG_W'($urandom_range(64, 127));
						h_val = CFG_W'($urandom_range(0, 2));
					end
					1: begin
						w_val = CFG_W'($urandom_range(0, 2));
						h_val = CFG_W'($urandom_range(64, 127));
					end
					2: begin
						w_val = CFG_W'($urandom_range(0, 1));
						h_val = CFG_W'($urandom_range(0, 1));
					end
					default: begin
						w_val = CFG_W'($urandom_range(1, 8));
						h_val = CFG_W'($urandom_range(1, 8));
					end
				endcase
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_IMAGE_WIDTH, w_val);
					write_reg(REG_IMAGE_HEIGHT, h_val);
				end else begin
					write_reg(REG_IMAGE_HEIGHT, h_val);
					write_reg(REG_IMAGE_WIDTH, w_val);
				end
			end
			m_val = MODE_W'($urandom_range(0, 7));
			write_reg(REG_TRANSFORM_MODE, CFG_W'(m_val));
			end_writes();
			idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);

			total = eff_dim(plan_w, MAX_W) * eff_dim(plan_h, MAX_H);
			if (total > loaded_span || $urandom_range(0, 2) == 0) begin
				for (k = 0; k < total; k++)
					queue_load(rand_pixel());
			end else if ($urandom_range(0, 2) == 0) begin
				// partial reload over the old image
				for (k = $urandom_range(1, total); k > 0; k--)
					queue_load(rand_pixel());
			end

			n_emit = $urandom_range(1, 2 * total + 1);
			if (n_emit > 160)
				n_emit = $urandom_range(total, 160);
			pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_emit - 1) : n_emit;
			for (k = 0; k < n_emit; k++) begin
				if (k == pause_at)
					drain();
				if ($urandom_range(0, 11) == 0)
					queue_load(rand_pixel());
				queue_emit();
			end
			drain();
		end

		drain();
		repeat (6) @(posedge clk);
		if (want_results.size() != 0) begin
			mismatches++;
			$display("%0d pixel results never arrived", want_results.size());
		end
		$display("%0d commands, %0d pixel results (%0d image ends) over %0d register settings",
			n_items, n_results, n_last, n_settings);
		$display("sizes from one pixel to 64 wide/high, all transforms, unused codes and saturation");
		if (mismatches == 0)
			$display("tb_image_rotate_mirror_engine_core passed");
		else
			$display("tb_image_rotate_mirror_engine_core failed");
		$finish;
	end

endmodule

### image_rotate_mirror_engine_core.f
src/rime_pkg.sv
src/rime_ram.sv
src/rime_front.sv
src/rime_queue.sv
src/rime_back.sv
src/image_rotate_mirror_engine_core.sv
test/tb_image_rotate_mirror_engine_core.sv
